### rtl/lcdp_pkg.sv
package lcdp_pkg;

    // Image geometry and store size
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 512;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    // Field and register widths
    localparam int PIX_W      = 19;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int DEPTH_W    = 16;

    localparam logic [DEPTH_W-1:0] CLEAR_DEPTH = 16'd65534;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT   = 16'd65535;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd512;
    localparam logic [31:0]         ZOFF_RESET   = 32'd19661;

    // Iteration counts
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 63;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FOCAL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWOFF = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZOFF   = 3'd4;

    // Request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_POINT = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [2:0] {
        MUL_XX = 3'd0,
        MUL_YY = 3'd1,
        MUL_FZ = 3'd2,
        MUL_WP = 3'd3,
        MUL_MM = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic              capture;
        logic              zz_en;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              r2_load;
        logic              r2_add;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              cordic_init;
        logic              cordic_step;
        logic              div_init;
        logic              div_step;
        logic              col_load;
        logic              row_sum;
        logic              row_trunc;
        logic              mm_load;
        logic              mem_clr;
        logic              mem_rd_pix;
        logic              mem_rd_pt;
        logic              rd_load;
        logic              upd;
        logic              out_load;
        logic [ADDR_W-1:0] step;
    } lcdp_cmd_t;

    typedef struct packed {
        logic rq_zero;
        logic in_image;
    } lcdp_stat_t;

    // atan(2^-i) in turns, Q0.32
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/lcdp_ctrl.sv
module lcdp_ctrl import lcdp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    output logic       m_valid,
    input  logic       m_ready,
    output lcdp_cmd_t  cmd,
    input  lcdp_stat_t stat
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_CLEAR   = 16'h0002,
        S_RDADDR  = 16'h0004,
        S_RDDATA  = 16'h0008,
        S_SQX     = 16'h0010,
        S_SQY     = 16'h0020,
        S_SUM     = 16'h0040,
        S_ROOT    = 16'h0080,
        S_MULF    = 16'h0100,
        S_DIVINIT = 16'h0200,
        S_DIV     = 16'h0400,
        S_ROWQ    = 16'h0800,
        S_ROWT    = 16'h1000,
        S_CHECK   = 16'h2000,
        S_UPD     = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] step_reg, step_next;
    logic              reply_reg, reply_next;
    logic              m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Sequencer
    always_comb begin
        cmd          = '0;
        cmd.step     = step_reg;
        state_next   = state_reg;
        step_next    = step_reg;
        reply_next   = reply_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    case (s_req_type)
                        REQ_CLEAR: begin
                            state_next = S_CLEAR;
                            reply_next = 1'b1;
                        end
                        REQ_POINT: state_next = S_SQX;
                        REQ_READ:  state_next = S_RDADDR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                cmd.mem_clr = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == ADDR_W'(STORE_SIZE - 1)) begin
                    step_next  = '0;
                    state_next = reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_RDADDR: begin
                cmd.mem_rd_pix = 1'b1;
                state_next     = S_RDDATA;
            end
            S_RDDATA: begin
                cmd.rd_load = 1'b1;
                state_next  = S_DONE;
            end
            S_SQX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XX;
                cmd.zz_en   = 1'b1;
                state_next  = S_SQY;
            end
            S_SQY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_YY;
                cmd.r2_load = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.r2_add      = 1'b1;
                cmd.sqrt_init   = 1'b1;
                cmd.cordic_init = 1'b1;
                step_next       = '0;
                state_next      = S_ROOT;
            end
            S_ROOT: begin
                // square root and angle iterate side by side
                cmd.sqrt_step   = 1'b1;
                cmd.cordic_step = (step_reg < ADDR_W'(CORDIC_STEPS));
                step_next       = step_reg + 1'b1;
                if (step_reg == ADDR_W'(SQRT_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = S_MULF;
                end
            end
            S_MULF: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FZ;
                state_next  = stat.rq_zero ? S_DONE : S_DIVINIT;
            end
            S_DIVINIT: begin
                cmd.div_init = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_WP;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cmd.col_load = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == ADDR_W'(DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = S_ROWQ;
                end
            end
            S_ROWQ: begin
                cmd.row_sum = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MM;
                state_next  = S_ROWT;
            end
            S_ROWT: begin
                cmd.row_trunc = 1'b1;
                cmd.mm_load   = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (stat.in_image) begin
                    cmd.mem_rd_pt = 1'b1;
                    state_next    = S_UPD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_UPD: begin
                cmd.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Reset starts with a clearing pass that sends no word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            step_reg    <= '0;
            reply_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            reply_reg   <= reply_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    a_clear_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_clr && (step_reg != ADDR_W'(STORE_SIZE - 1)) |=> cmd.mem_clr)
        else $error("clearing pass cut short");

endmodule

### rtl/lcdp_datapath.sv
module lcdp_datapath import lcdp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic signed [31:0]    s_x_pos,
    input  logic signed [31:0]    s_y_pos,
    input  logic signed [31:0]    s_z_pos,
    input  logic [PIX_W-1:0]      s_pixel_index,
    input  lcdp_cmd_t             cmd,
    output lcdp_stat_t            stat,
    output logic [COL_W-1:0]      m_column,
    output logic [ROW_W-1:0]      m_row,
    output logic                  m_in_image,
    output logic [DEPTH_W-1:0]    m_depth_mm,
    output logic                  m_depth_replaced
);

    // Configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic signed [31:0]  focal_reg, rowoff_reg, zoff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            focal_reg  <= '0;
            rowoff_reg <= '0;
            zoff_reg   <= ZOFF_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_FOCAL:  focal_reg  <= cfg_wdata;
                CFG_ROWOFF: rowoff_reg <= cfg_wdata;
                CFG_ZOFF:   zoff_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input word
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [PIX_W-1:0]   pix_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg   <= s_x_pos;
            y_reg   <= s_y_pos;
            z_reg   <= s_z_pos;
            pix_reg <= s_pixel_index;
        end
    end

    logic [31:0] ax, ay;
    assign ax = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign ay = y_reg[31] ? (~y_reg + 32'd1) : y_reg;

    // Offset z, saturated
    logic signed [32:0] zsum;
    logic signed [31:0] zz_reg;
    assign zsum = {z_reg[31], z_reg} + {zoff_reg[31], zoff_reg};

    always_ff @(posedge aclk) begin
        if (cmd.zz_en) begin
            if (zsum[32] != zsum[31])
                zz_reg <= zsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                zz_reg <= zsum[31:0];
        end
    end

    // Shared multiplier
    logic [31:0]        root_reg;
    logic [31:0]        ang_reg;
    logic [31:0]        phi;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    assign phi = HALF_TURN - ang_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_XX: begin
                mul_a = {1'b0, ax};
                mul_b = {1'b0, ax};
            end
            MUL_YY: begin
                mul_a = {1'b0, ay};
                mul_b = {1'b0, ay};
            end
            MUL_FZ: begin
                mul_a = {focal_reg[31], focal_reg};
                mul_b = {zz_reg[31], zz_reg};
            end
            MUL_WP: begin
                mul_a = {{(33 - WIDTH_W){1'b0}}, width_reg};
                mul_b = {1'b0, phi};
            end
            MUL_MM: begin
                mul_a = {1'b0, root_reg};
                mul_b = 33'sd1000;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // Squared range, consumed two bits a step by the root
    logic [63:0] r2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.r2_load)
            r2_reg <= prod_reg[63:0];
        else if (cmd.r2_add)
            r2_reg <= r2_reg + prod_reg[63:0];
        else if (cmd.sqrt_step)
            r2_reg <= {r2_reg[61:0], 2'b00};
    end

    // Digit-by-digit square root, one root bit a step
    logic [33:0] srem_reg;
    logic [34:0] s_t, s_trial, s_diff;
    logic        s_ge;

    assign s_t     = {srem_reg[32:0], r2_reg[63:62]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_ge    = (s_t >= s_trial);
    assign s_diff  = s_t - s_trial;

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            srem_reg <= s_ge ? s_diff[33:0] : s_t[33:0];
            root_reg <= {root_reg[30:0], s_ge};
        end
    end

    // CORDIC vectoring for the azimuth, in turns
    logic signed [63:0] cx_reg, cy_reg;
    logic signed [63:0] xe, ye, xm, ym, c_dx, c_dy;
    logic               yzero_reg;
    logic [4:0]         c_i;
    logic [31:0]        c_atan;

    assign xe     = {{32{x_reg[31]}}, x_reg};
    assign ye     = {{32{y_reg[31]}}, y_reg};
    assign xm     = x_reg[31] ? -xe : xe;
    assign ym     = x_reg[31] ? -ye : ye;
    assign c_i    = cmd.step[4:0];
    assign c_dx   = cy_reg >>> c_i;
    assign c_dy   = cx_reg >>> c_i;
    assign c_atan = atan_turns(c_i);

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            // left half is mirrored through the origin
            cx_reg    <= xm <<< 29;
            cy_reg    <= ym <<< 29;
            ang_reg   <= x_reg[31] ? HALF_TURN : 32'd0;
            yzero_reg <= (y_reg == 32'sd0);
        end else if (cmd.cordic_step && !yzero_reg) begin
            if (cy_reg > 64'sd0) begin
                cx_reg  <= cx_reg + c_dx;
                cy_reg  <= cy_reg - c_dy;
                ang_reg <= ang_reg + c_atan;
            end else begin
                cx_reg  <= cx_reg - c_dx;
                cy_reg  <= cy_reg + c_dy;
                ang_reg <= ang_reg - c_atan;
            end
        end
    end

    // Restoring divide of |focal*zz| by the range, one quotient bit a step
    logic               qneg_reg;
    logic [62:0]        num_reg;
    logic [31:0]        drem_reg;
    logic signed [65:0] pmag;
    logic [32:0]        d_t, d_diff;
    logic               d_ge;

    assign pmag   = prod_reg[65] ? -prod_reg : prod_reg;
    assign d_t    = {drem_reg, num_reg[62]};
    assign d_ge   = (d_t >= {1'b0, root_reg});
    assign d_diff = d_t - {1'b0, root_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            // the row term is minus the product
            qneg_reg <= (prod_reg > 66'sd0);
            num_reg  <= pmag[62:0];
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            drem_reg <= d_ge ? d_diff[31:0] : d_t[31:0];
            num_reg  <= {num_reg[61:0], d_ge};
        end
    end

    // Column, row and depth
    logic [WIDTH_W-1:0] col_reg;
    logic signed [63:0] sum_reg, roff64, qmag, biased;
    logic signed [47:0] row_reg;
    logic [DEPTH_W-1:0] mm_reg;

    assign roff64 = {{32{rowoff_reg[31]}}, rowoff_reg};
    assign qmag   = {1'b0, num_reg};
    assign biased = sum_reg + (sum_reg[63] ? 64'sd65535 : 64'sd0);

    always_ff @(posedge aclk) begin
        if (cmd.col_load)
            col_reg <= prod_reg[32 +: WIDTH_W];
        if (cmd.row_sum)
            sum_reg <= qneg_reg ? (roff64 - qmag) : (roff64 + qmag);
        if (cmd.row_trunc)
            row_reg <= biased[63:16];
        if (cmd.mm_load)
            mm_reg <= (prod_reg[65:32] != '0) ? DEPTH_SAT : prod_reg[31:16];
    end

    // Bounds against the image in use
    logic [31:0]       effw, effh;
    logic              col_ok, row_ok;
    logic [ADDR_W-1:0] idx;

    assign effw   = (32'(width_reg) < MAX_WIDTH) ? 32'(width_reg) : MAX_WIDTH;
    assign effh   = (32'(height_reg) < MAX_HEIGHT) ? 32'(height_reg) : MAX_HEIGHT;
    assign col_ok = (32'(col_reg) < effw);
    assign row_ok = !row_reg[47] && (row_reg[46:0] < 47'(effh));
    assign idx    = ADDR_W'(32'(row_reg[ROW_W-1:0]) * MAX_WIDTH + 32'(col_reg));

    assign stat.rq_zero  = (root_reg == '0);
    assign stat.in_image = col_ok && row_ok;

    // Depth store
    logic [DEPTH_W-1:0] mem [STORE_SIZE];
    logic [DEPTH_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               lower, pix_ok;

    assign rd_addr = cmd.mem_rd_pix ? ADDR_W'(pix_reg) : idx;
    assign lower   = (rd_data_reg > mm_reg);
    assign pix_ok  = (32'(pix_reg) < STORE_SIZE);

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd_pix || cmd.mem_rd_pt)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_clr)
            mem[cmd.step] <= CLEAR_DEPTH;
        else if (cmd.upd && lower)
            mem[idx] <= mm_reg;
    end

    // Result being built, then the output register
    logic [COL_W-1:0]   res_col_reg;
    logic [ROW_W-1:0]   res_row_reg;
    logic               res_in_reg, res_rep_reg;
    logic [DEPTH_W-1:0] res_depth_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_col_reg   <= '0;
            res_row_reg   <= '0;
            res_in_reg    <= 1'b0;
            res_depth_reg <= '0;
            res_rep_reg   <= 1'b0;
        end else if (cmd.rd_load) begin
            res_depth_reg <= pix_ok ? rd_data_reg : '0;
        end else if (cmd.upd) begin
            res_col_reg   <= col_reg[COL_W-1:0];
            res_row_reg   <= row_reg[ROW_W-1:0];
            res_in_reg    <= 1'b1;
            res_depth_reg <= mm_reg;
            res_rep_reg   <= lower;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_column         <= res_col_reg;
            m_row            <= res_row_reg;
            m_in_image       <= res_in_reg;
            m_depth_mm       <= res_depth_reg;
            m_depth_replaced <= res_rep_reg;
        end
    end

    a_upd_sets_in: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd |=> res_in_reg)
        else $error("store update without in-image flag");

    a_rep_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && res_rep_reg |=> m_in_image)
        else $error("replaced flag on a point outside the image");

    a_no_rd_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_clr && (cmd.mem_rd_pix || cmd.mem_rd_pt)))
        else $error("store read during clearing pass");

endmodule

### rtl/lidar_cylindrical_depth_projector.sv
// Channel   Handshake                Payload
// s_        s_valid / s_ready        s_req_type, s_x_pos, s_y_pos, s_z_pos, s_pixel_index
// m_        m_valid / m_ready        m_column, m_row, m_in_image, m_depth_mm, m_depth_replaced
// cfg_      cfg_we (no back-pressure) cfg_addr, cfg_wdata
//
// One word at a time. A point runs 32 square-root steps
// (the 24 CORDIC steps run alongside) and 63 divide steps on the shared
// iterative units, plus capture, multiply, bounds and store access.
// A read addresses the store and then loads the result; a clear sweeps the
// store one entry a cycle, all 524288 entries. After reset the same clearing
// pass runs before s_ready rises; configuration writes are taken throughout.
// A finished word waits in the output register while the next is accepted.
module lidar_cylindrical_depth_projector import lcdp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic signed [31:0]    s_x_pos,
    input  logic signed [31:0]    s_y_pos,
    input  logic signed [31:0]    s_z_pos,
    input  logic [PIX_W-1:0]      s_pixel_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COL_W-1:0]      m_column,
    output logic [ROW_W-1:0]      m_row,
    output logic                  m_in_image,
    output logic [DEPTH_W-1:0]    m_depth_mm,
    output logic                  m_depth_replaced
);

    lcdp_cmd_t  cmd;
    lcdp_stat_t stat;

    // Sequencer
    lcdp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Arithmetic, depth store and result registers
    lcdp_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_x_pos          (s_x_pos),
        .s_y_pos          (s_y_pos),
        .s_z_pos          (s_z_pos),
        .s_pixel_index    (s_pixel_index),
        .cmd              (cmd),
        .stat             (stat),
        .m_column         (m_column),
        .m_row            (m_row),
        .m_in_image       (m_in_image),
        .m_depth_mm       (m_depth_mm),
        .m_depth_replaced (m_depth_replaced)
    );

endmodule

### bench/tb_lidar_cylindrical_depth_projector.sv
`timescale 1ns / 100ps

module tb_lidar_cylindrical_depth_projector;
    import lcdp_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         RUN_LIMIT  = 8_000_000;
    localparam int         LONG_HOLD  = 4000;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic               in_image;
        logic [DEPTH_W-1:0] depth_mm;
        logic               replaced;
    } pixel_res_t;

    typedef struct packed {
        logic [1:0]       req;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [PIX_W-1:0] pix;
        logic             fixed;
        pixel_res_t       want;
    } point_word_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [31:0]         focal;
        logic [31:0]         rowoff;
        logic [31:0]         zoff;
    } geometry_t;

    // atan(2^-i) in turns, Q0.32
    localparam logic [31:0] ATAN_LUT [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    localparam pixel_res_t NO_PIXEL = '0;

    // Directed words under the first geometry; typed expectations only where obvious
    localparam point_word_t DIRECTED [21] = '{
        '{REQ_READ,  32'h0, 32'h0, 32'h0, 19'd0, 1'b1, '{10'd0, 9'd0, 1'b0, CLEAR_DEPTH, 1'b0}},
        '{REQ_READ,  32'h0, 32'h0, 32'h0, 19'h7FFFF, 1'b1,
          '{10'd0, 9'd0, 1'b0, CLEAR_DEPTH, 1'b0}},
        '{REQ_POINT, 32'h0, 32'h0, 32'h0, 19'd0, 1'b1, NO_PIXEL},
        '{REQ_UNUSED, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, 19'h7FFFF, 1'b1, NO_PIXEL},
        '{REQ_POINT, 32'h000A_0000, 32'h0, 32'h0, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'hFFF6_0000, 32'h0, 32'h0, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h0, 32'h0005_0000, 32'h0, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h0, 32'hFFFB_0000, 32'h0, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h0006_0000, 32'h0008_0000, 32'hFFFE_0000, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h1, 32'h0, 32'h0, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'h0, 32'h0, 32'h5, 19'd0, 1'b1, NO_PIXEL},
        '{REQ_POINT, 32'h0002_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_POINT, 32'hFFFE_0000, 32'h0001_0000, 32'h8000_0000, 19'd0, 1'b0, NO_PIXEL},
        '{REQ_READ,  32'h0, 32'h0, 32'h0, 19'h2AAAA, 1'b0, NO_PIXEL},
        '{REQ_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 19'h55555, 1'b1, NO_PIXEL},
        '{REQ_READ,  32'h0, 32'h0, 32'h0, 19'd0, 1'b1, '{10'd0, 9'd0, 1'b0, CLEAR_DEPTH, 1'b0}},
        '{REQ_POINT, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, 19'd0, 1'b0, NO_PIXEL}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [31:0]           cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type = '0;
    logic signed [31:0]    s_x_pos = '0;
    logic signed [31:0]    s_y_pos = '0;
    logic signed [31:0]    s_z_pos = '0;
    logic [PIX_W-1:0]      s_pixel_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COL_W-1:0]      m_column;
    logic [ROW_W-1:0]      m_row;
    logic                  m_in_image;
    logic [DEPTH_W-1:0]    m_depth_mm;
    logic                  m_depth_replaced;

    lidar_cylindrical_depth_projector u_dut (.*);

    // Predictor state
    logic [DEPTH_W-1:0] model_depth [STORE_SIZE];
    geometry_t          geom;
    pixel_res_t         pending_pixels [$];
    int                 hit_pixels [$];

    int errors = 0;
    int words_sent = 0;
    int words_seen = 0;
    int points_in = 0;
    int reads_sent = 0;
    int clears_sent = 0;
    int settings_used = 0;
    int cycles = 0;
    int rx_hold = 0;
    bit long_hold_done = 0;
    bit calm = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == RUN_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding",
                     cycles, pending_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly short gaps, a few long, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // atan2(y, x) in turns, Q0.32
    function automatic logic [31:0] azimuth_turns(longint x, longint y);
        logic [31:0] a;
        longint cx, cy, dx, dy;
        a = '0;
        if (y == 0) return (x < 0) ? HALF_TURN : 32'h0;
        if (x < 0) begin
            x = -x;
            y = -y;
            a = HALF_TURN;
        end
        cx = x * (longint'(1) << 29);
        cy = y * (longint'(1) << 29);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx += dx;
                cy -= dy;
                a += ATAN_LUT[i];
            end else begin
                cx -= dx;
                cy += dy;
                a -= ATAN_LUT[i];
            end
        end
        return a;
    endfunction

    // Expected word for one request; updates the depth image
    function automatic pixel_res_t project_word(point_word_t w);
        pixel_res_t  res;
        longint      x, y, zz, q, rowv, prod;
        logic [63:0] ax, ay, rq, colv, mm;
        logic [31:0] phi;
        int          effw, effh, idx;
        res = '0;
        case (w.req)
            REQ_CLEAR: foreach (model_depth[i]) model_depth[i] = CLEAR_DEPTH;
            REQ_READ:  res.depth_mm = model_depth[w.pix];
            REQ_POINT: begin
                x = longint'($signed(w.x));
                y = longint'($signed(w.y));
                zz = longint'($signed(w.z)) + longint'($signed(geom.zoff));
                if (zz > 64'sh7FFF_FFFF) zz = 64'sh7FFF_FFFF;
                if (zz < -64'sh8000_0000) zz = -64'sh8000_0000;
                ax = (x < 0) ? -x : x;
                ay = (y < 0) ? -y : y;
                rq = root_floor(ax * ax + ay * ay);
                effw = (geom.width < MAX_WIDTH) ? int'(geom.width) : MAX_WIDTH;
                effh = (geom.height < MAX_HEIGHT) ? int'(geom.height) : MAX_HEIGHT;
                if (rq != 0) begin
                    phi = HALF_TURN - azimuth_turns(x, y);
                    colv = (64'(geom.width) * 64'(phi)) >> 32;
                    prod = longint'($signed(geom.focal)) * zz;
                    q = (-prod) / longint'(rq);
                    rowv = (q + longint'($signed(geom.rowoff))) / 65536;
                    if (colv < effw && rowv >= 0 && rowv < effh) begin
                        mm = (rq * 1000) >> 16;
                        if (mm > 65535) mm = 65535;
                        idx = int'(rowv) * MAX_WIDTH + int'(colv);
                        res.column = colv[COL_W-1:0];
                        res.row = rowv[ROW_W-1:0];
                        res.in_image = 1'b1;
                        res.depth_mm = mm[DEPTH_W-1:0];
                        if (model_depth[idx] > mm) begin
                            model_depth[idx] = mm[DEPTH_W-1:0];
                            res.replaced = 1'b1;
                        end
                        if (hit_pixels.size() < 256) hit_pixels = {hit_pixels, idx};
                        else hit_pixels[$urandom_range(0, 255)] = idx;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one word and hold it until taken; valid is left high
    task automatic send_word(point_word_t w);
        pixel_res_t guess;
        s_valid <= 1'b1;
        s_req_type <= w.req;
        s_x_pos <= w.x;
        s_y_pos <= w.y;
        s_z_pos <= w.z;
        s_pixel_index <= w.pix;
        do @(posedge aclk); while (!s_ready);
        guess = project_word(w);
        pending_pixels = {pending_pixels, (w.fixed ? w.want : guess)};
        words_sent++;
        if (w.req == REQ_POINT && guess.in_image) points_in++;
        if (w.req == REQ_READ) reads_sent++;
        if (w.req == REQ_CLEAR) clears_sent++;
    endtask

    // Drop valid after a word if a gap follows or the batch ends
    task automatic pace(bit last);
        int g;
        g = pick_gap();
        if (g > 0 || last) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all five registers in turn; the task itself does not wait for idle
    task automatic program_geometry(geometry_t g);
        logic [31:0] vals [5];
        vals = '{32'(g.width), 32'(g.height), g.focal, g.rowoff, g.zoff};
        for (int i = 0; i < 5; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= (i == 0) ? CFG_WIDTH : (i == 1) ? CFG_HEIGHT :
                        (i == 2) ? CFG_FOCAL : (i == 3) ? CFG_ROWOFF : CFG_ZOFF;
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        geom = g;
        settings_used++;
    endtask

    function automatic logic [31:0] coord(int span_m);
        int r;
        logic [31:0] ext [5];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
        r = $urandom_range(0, 99);
        if (r < 65) return 32'($signed($urandom_range(0, 2 * span_m * 65536))) -
                           32'(span_m * 65536);
        if (r < 80) return $urandom;
        if (r < 88) return 32'h0;
        if (r < 95) return 32'($urandom_range(0, 6)) - 32'd3;
        return ext[$urandom_range(0, 4)];
    endfunction

    function automatic point_word_t random_word();
        point_word_t w;
        int r;
        w = '0;
        w.pix = PIX_W'($urandom_range(0, STORE_SIZE - 1));
        w.x = coord(60);
        w.y = coord(60);
        w.z = coord(5);
        r = $urandom_range(0, 99);
        if (r < 78) begin
            w.req = REQ_POINT;
        end else if (r < 95) begin
            w.req = REQ_READ;
            if (hit_pixels.size() != 0 && $urandom_range(0, 9) < 7)
                w.pix = PIX_W'(hit_pixels[$urandom_range(0, hit_pixels.size() - 1)]);
        end else begin
            w.req = REQ_UNUSED;
        end
        return w;
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            send_word(random_word());
            pace(i == n - 1);
        end
    endtask

    // Result side: random stalls plus one long hold-off that backs up the input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!long_hold_done && words_seen >= 250) begin
                long_hold_done <= 1'b1;
                rx_hold <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else begin
                int g;
                g = pick_gap();
                rx_hold <= (g > 0) ? g - 1 : 0;
                m_ready <= (g == 0);
            end
        end
    end

    // Compare each taken word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_pixels.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                pixel_res_t e;
                e = pending_pixels.pop_front();
                if (m_column !== e.column) begin
                    $error("column expected %0d got %0d", e.column, m_column);
                    errors++;
                end
                if (m_row !== e.row) begin
                    $error("row expected %0d got %0d", e.row, m_row);
                    errors++;
                end
                if (m_in_image !== e.in_image) begin
                    $error("in_image expected %0d got %0d", e.in_image, m_in_image);
                    errors++;
                end
                if (m_depth_mm !== e.depth_mm) begin
                    $error("depth_mm expected %0d got %0d", e.depth_mm, m_depth_mm);
                    errors++;
                end
                if (m_depth_replaced !== e.replaced) begin
                    $error("depth_replaced expected %0d got %0d", e.replaced,
                           m_depth_replaced);
                    errors++;
                end
            end
        end
    end

    initial begin
        point_word_t clr;
        int          settle;
        foreach (model_depth[i]) model_depth[i] = CLEAR_DEPTH;
        geom = '{WIDTH_RESET, HEIGHT_RESET, 32'h0, 32'h0, ZOFF_RESET};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words
        program_geometry('{11'd1024, 10'd512, 32'h0040_0000, 32'h0100_0000, ZOFF_RESET});
        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i]);
            pace(i == $size(DIRECTED) - 1);
        end
        drain();

        // Back-to-back traffic with no idling on the input side
        calm = 1;
        random_batch(300);
        drain();
        calm = 0;

        // Extremes: over-wide geometry, most negative focal, saturating offset
        program_geometry('{11'd2047, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        random_batch(200);
        drain();

        program_geometry('{11'd1, 10'd1, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF});
        random_batch(150);
        drain();

        // Zero-sized image puts every point outside
        program_geometry('{11'd0, 10'd0, 32'h0010_0000, 32'h0, 32'h0});
        random_batch(100);
        drain();

        program_geometry('{11'd700, 10'd300, 32'h0014_0000, 32'h0096_0000, 32'hFFFF_0000});
        clr = '0;
        clr.req = REQ_CLEAR;
        clr.fixed = 1'b1;
        send_word(clr);
        pace(1'b0);
        random_batch(400);
        drain();

        program_geometry('{WIDTH_RESET, HEIGHT_RESET, 32'h0, 32'h0, ZOFF_RESET});
        random_batch(400);

        drain();
        settle = 0;
        while (settle < 300) begin
            @(posedge aclk);
            settle++;
        end
        $display("Ran %0d words over %0d register settings: %0d points landed, %0d reads, %0d clears",
                 words_sent, settings_used, points_in, reads_sent, clears_sent);
        $display("Long output hold-off %0s, %0d words left over",
                 long_hold_done ? "done" : "not reached", pending_pixels.size());
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
